@@ hdl/tcw_pkg.sv @@
package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int OPQ_DEPTH   = 4;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
   localparam logic [15:0] BLANK_RESET      = {TEXT_COLOR_RESET, CH_SPACE};

   typedef enum logic [2:0] {
      KIND_PUT_BOTH   = 3'd0,
      KIND_PUT_BACK   = 3'd1,
      KIND_PUT_AT     = 3'd2,
      KIND_SET_CURSOR = 3'd3,
      KIND_CLEAR_ALL  = 3'd4,
      KIND_CLEAR_BACK = 3'd5,
      KIND_FLIP       = 3'd6,
      KIND_READ       = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_PUT_BOTH   = 3'd1,
      OP_PUT_BACK   = 3'd2,
      OP_CLEAR_ALL  = 3'd3,
      OP_CLEAR_BACK = 3'd4,
      OP_FLIP       = 3'd5,
      OP_READ       = 3'd6
   } op_code_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_code;
      logic [7:0] col;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [15:0] cell_data;
      logic        range_error;
   } rsp_type;

   typedef struct packed {
      op_code_type code;
      logic [15:0] cell_word;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic        range_error;
   } op_type;

endpackage

@@ hdl/tcw_front.sv @@
module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [7:0]                          csr_wr_data,
   input  logic                                req_push,
   input  req_type                             req_data,
   output logic                                req_full,
   input  logic                                queue_full,
   input  logic                                init_busy,
   output logic                                op_push,
   output op_type                              op_data,
   output logic [$clog2(COLUMNS*ROWS)-1:0]     op_addr
);

   localparam int AW    = $clog2(COLUMNS*ROWS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int CW1   = COL_W + 1;
   localparam int RW1   = ROW_W + 1;

   logic [7:0]       text_color_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             accept;
   logic [CW1-1:0]   tab_sum;
   logic [CW1-1:0]   put_col;
   logic [RW1-1:0]   put_row;
   logic             put_print;
   logic [COL_W-1:0] set_col;
   logic [ROW_W-1:0] set_row;
   logic             on_screen;
   logic             use_cursor;
   logic [AW-1:0]    addr_row;
   logic [AW-1:0]    addr_col;
   logic [COL_W-1:0] next_col;
   logic [ROW_W-1:0] next_row;
   op_code_type      code;
   logic             err;
   logic [7:0]       cell_char;

   assign req_full = queue_full | init_busy;
   assign accept   = req_push & ~req_full;

   // Cursor motion for a put at the cursor; a column past the edge wraps to the next row.
   always_comb begin
      tab_sum   = {1'b0, col_ff} + CW1'(8);
      put_print = 1'b0;
      put_row   = {1'b0, row_ff};
      case (req_data.char_code)
         CH_NEWLINE: begin
            put_col = '0;
            put_row = {1'b0, row_ff} + RW1'(1);
         end
         CH_TAB: begin
            put_col = {tab_sum[COL_W:3], 3'b000};
         end
         CH_RETURN: begin
            put_col = '0;
         end
         default: begin
            put_col   = {1'b0, col_ff} + CW1'(1);
            put_print = 1'b1;
         end
      endcase
      if (put_col >= CW1'(COLUMNS)) begin
         put_col = '0;
         put_row = put_row + RW1'(1);
      end
      if (put_row >= RW1'(ROWS)) begin
         put_row = '0;
      end
   end

   always_comb begin
      set_col = ({1'b0, req_data.col} >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                       : COL_W'(req_data.col);
      set_row = ({1'b0, req_data.row} >= 9'(ROWS)) ? ROW_W'(ROWS - 1)
                                                    : ROW_W'(req_data.row);
      on_screen = ({1'b0, req_data.col} < 9'(COLUMNS)) &&
                  ({1'b0, req_data.row} < 9'(ROWS));
   end

   always_comb begin
      next_col   = col_ff;
      next_row   = row_ff;
      code       = OP_NONE;
      err        = 1'b0;
      use_cursor = 1'b0;
      cell_char  = req_data.char_code;
      case (req_data.kind)
         KIND_PUT_BOTH, KIND_PUT_BACK: begin
            next_col   = COL_W'(put_col);
            next_row   = ROW_W'(put_row);
            use_cursor = 1'b1;
            if (put_print) begin
               code = (req_data.kind == KIND_PUT_BOTH) ? OP_PUT_BOTH : OP_PUT_BACK;
            end
         end
         KIND_PUT_AT: begin
            if (on_screen) begin
               code = OP_PUT_BOTH;
            end else begin
               err = 1'b1;
            end
         end
         KIND_SET_CURSOR: begin
            next_col = set_col;
            next_row = set_row;
         end
         KIND_CLEAR_ALL, KIND_CLEAR_BACK: begin
            next_col  = '0;
            next_row  = '0;
            cell_char = CH_SPACE;
            code = (req_data.kind == KIND_CLEAR_ALL) ? OP_CLEAR_ALL : OP_CLEAR_BACK;
         end
         KIND_FLIP: begin
            code = OP_FLIP;
         end
         KIND_READ: begin
            if (on_screen) begin
               code = OP_READ;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            code = OP_NONE;
         end
      endcase
   end

   // Off-screen coordinates truncate here, but no store access is issued for them.
   assign addr_row = use_cursor ? AW'(row_ff) : AW'(req_data.row);
   assign addr_col = use_cursor ? AW'(col_ff) : AW'(req_data.col);
   assign op_addr  = addr_row * AW'(COLUMNS) + addr_col;

   assign op_push             = accept;
   assign op_data.code        = code;
   assign op_data.cell_word   = {text_color_ff, cell_char};
   assign op_data.cursor_col  = 7'(next_col);
   assign op_data.cursor_row  = 5'(next_row);
   assign op_data.range_error = err;

   assign col_in = accept ? next_col : col_ff;
   assign row_in = accept ? next_row : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            text_color_ff <= csr_wr_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ hdl/tcw_opq.sv @@
module tcw_opq import tcw_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = OPQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/tcw_back.sv @@
module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            op_empty,
   input  op_type                          op_data,
   input  logic [$clog2(COLUMNS*ROWS)-1:0] op_addr,
   output logic                            op_pop,
   output logic                            init_busy,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output rsp_type                         rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_CLEAR  = 6'b001000,
      ST_FLIP   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   logic [15:0] disp_mem [CELLS];
   logic [15:0] back_mem [CELLS];

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   op_type        cur_ff, cur_in;
   logic          flip_pend_ff;
   logic [AW-1:0] flip_addr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic [15:0]   disp_rd_ff;
   logic [15:0]   back_rd_ff;

   logic          out_free;
   logic          last;
   logic          rsp_push;
   rsp_type       rsp_next;
   logic          disp_we, back_we, disp_re, back_re;
   logic [AW-1:0] disp_wa, back_wa, disp_ra, back_ra;
   logic [15:0]   disp_wd, back_wd;

   assign out_free  = ~rsp_valid_ff | rsp_pop;
   assign last      = (cnt_ff == AW'(CELLS - 1));
   assign init_busy = (state_ff == ST_INIT);
   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in             = state_ff;
      cnt_in               = cnt_ff;
      cur_in               = cur_ff;
      op_pop               = 1'b0;
      rsp_push             = 1'b0;
      rsp_next.cursor_col  = cur_ff.cursor_col;
      rsp_next.cursor_row  = cur_ff.cursor_row;
      rsp_next.cell_data   = '0;
      rsp_next.range_error = cur_ff.range_error;
      disp_we              = 1'b0;
      disp_wa              = cnt_ff;
      disp_wd              = cur_ff.cell_word;
      back_we              = 1'b0;
      back_wa              = cnt_ff;
      back_wd              = cur_ff.cell_word;
      disp_re              = 1'b0;
      disp_ra              = op_addr;
      back_re              = 1'b0;
      back_ra              = cnt_ff;

      // The copy into the display store is written in the cycle after its back-store read.
      if (flip_pend_ff) begin
         disp_we = 1'b1;
         disp_wa = flip_addr_ff;
         disp_wd = back_rd_ff;
      end

      case (state_ff)
         ST_INIT: begin
            disp_we = 1'b1;
            back_we = 1'b1;
            disp_wd = BLANK_RESET;
            back_wd = BLANK_RESET;
            cnt_in  = cnt_ff + AW'(1);
            if (last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!op_empty && out_free) begin
               op_pop               = 1'b1;
               cur_in               = op_data;
               rsp_next.cursor_col  = op_data.cursor_col;
               rsp_next.cursor_row  = op_data.cursor_row;
               rsp_next.range_error = op_data.range_error;
               case (op_data.code)
                  OP_PUT_BOTH: begin
                     disp_we  = 1'b1;
                     disp_wa  = op_addr;
                     disp_wd  = op_data.cell_word;
                     back_we  = 1'b1;
                     back_wa  = op_addr;
                     back_wd  = op_data.cell_word;
                     rsp_push = 1'b1;
                  end
                  OP_PUT_BACK: begin
                     back_we  = 1'b1;
                     back_wa  = op_addr;
                     back_wd  = op_data.cell_word;
                     rsp_push = 1'b1;
                  end
                  OP_CLEAR_ALL, OP_CLEAR_BACK: begin
                     state_in = ST_CLEAR;
                  end
                  OP_FLIP: begin
                     state_in = ST_FLIP;
                  end
                  OP_READ: begin
                     disp_re  = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_push           = 1'b1;
               rsp_next.cell_data = disp_rd_ff;
               state_in           = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            back_we = 1'b1;
            disp_we = (cur_ff.code == OP_CLEAR_ALL);
            cnt_in  = cnt_ff + AW'(1);
            if (last) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FLIP: begin
            back_re = 1'b1;
            cnt_in  = cnt_ff + AW'(1);
            if (last) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (disp_we) begin
         disp_mem[disp_wa] <= disp_wd;
      end
      if (disp_re) begin
         disp_rd_ff <= disp_mem[disp_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_wa] <= back_wd;
      end
      if (back_re) begin
         back_rd_ff <= back_mem[back_ra];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      flip_addr_ff <= cnt_ff;
      if (rsp_push) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         flip_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         flip_pend_ff <= (state_ff == ST_FLIP);
         if (rsp_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ hdl/text_mode_char_writer.sv @@
// Channel    Ports                               Direction  Transaction when
// request    req_push, req_full, req_data        in         req_push && !req_full
// response   rsp_pop, rsp_empty, rsp_data        out        rsp_pop && !rsp_empty
// config     csr_wr_en, csr_wr_data              in         csr_wr_en
//
// Puts, cursor moves and rejected commands retire one per cycle through the back end,
// as long as the response register is free or being popped. A read passes through
// ST_READ because the display store read is registered. Clear and flip sweep the
// stores one cell a cycle, then reply from ST_FINISH. After reset a clearing pass
// blanks both stores; req_full is high during it. A four-entry command queue lets
// requests enter while the back end or the response side stalls.
module text_mode_char_writer import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int AW = $clog2(COLUMNS * ROWS);
   localparam int QW = AW + $bits(op_type);

   logic          op_push;
   op_type        front_op;
   logic [AW-1:0] front_addr;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   logic [QW-1:0] q_data;
   op_type        q_op;
   logic [AW-1:0] q_addr;
   logic          init_busy;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .queue_full  (q_full),
      .init_busy   (init_busy),
      .op_push     (op_push),
      .op_data     (front_op),
      .op_addr     (front_addr)
   );

   tcw_opq #(
      .WIDTH (QW),
      .DEPTH (OPQ_DEPTH)
   ) u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data ({front_addr, front_op}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign {q_addr, q_op} = q_data;

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (q_empty),
      .op_data   (q_op),
      .op_addr   (q_addr),
      .op_pop    (q_pop),
      .init_busy (init_busy),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/tcw_screen_checker.sv @@
module tcw_screen_checker import tcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  req_type    req_data,
   input  logic       rsp_pop,
   input  logic       rsp_empty,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         replies_checked,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = COLUMNS * ROWS;

   // Our own copy of the screen: what the display shows and what the back store holds.
   logic [15:0] disp_cells [CELLS];
   logic [15:0] back_cells [CELLS];
   int          cur_col;
   int          cur_row;
   logic [7:0]  attr;
   rsp_type     pending_replies [$];

   function automatic void fill_cells(input bit with_display);
      for (int i = 0; i < CELLS; i++) begin
         back_cells[i] = {attr, CH_SPACE};
         if (with_display) begin
            disp_cells[i] = {attr, CH_SPACE};
         end
      end
   endfunction

   function automatic void print_char(input logic [7:0] ch, input bit both);
      int idx;
      if (ch == CH_NEWLINE) begin
         cur_col = 0;
         cur_row++;
      end else if (ch == CH_TAB) begin
         cur_col = (cur_col + 8) & ~7;
      end else if (ch == CH_RETURN) begin
         cur_col = 0;
      end else begin
         idx = cur_row * COLUMNS + cur_col;
         back_cells[idx] = {attr, ch};
         if (both) begin
            disp_cells[idx] = {attr, ch};
         end
         cur_col++;
      end
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      // The screen never scrolls; the cursor simply wraps to the top row.
      if (cur_row >= ROWS) begin
         cur_row = 0;
      end
   endfunction

   function automatic rsp_type apply_command(input req_type cmd);
      rsp_type res;
      int      c;
      int      r;
      int      idx;
      bit      on_screen;
      res = '0;
      c = int'(cmd.col);
      r = int'(cmd.row);
      on_screen = (c < COLUMNS) && (r < ROWS);
      idx = r * COLUMNS + c;
      case (cmd.kind)
         KIND_PUT_BOTH: print_char(cmd.char_code, 1'b1);
         KIND_PUT_BACK: print_char(cmd.char_code, 1'b0);
         KIND_PUT_AT: begin
            if (on_screen) begin
               disp_cells[idx] = {attr, cmd.char_code};
               back_cells[idx] = {attr, cmd.char_code};
            end else begin
               res.range_error = 1'b1;
            end
         end
         KIND_SET_CURSOR: begin
            cur_col = (c >= COLUMNS) ? COLUMNS - 1 : c;
            cur_row = (r >= ROWS) ? ROWS - 1 : r;
         end
         KIND_CLEAR_ALL: begin
            fill_cells(1'b1);
            cur_col = 0;
            cur_row = 0;
         end
         KIND_CLEAR_BACK: begin
            fill_cells(1'b0);
            cur_col = 0;
            cur_row = 0;
         end
         KIND_FLIP: disp_cells = back_cells;
         KIND_READ: begin
            if (on_screen) begin
               res.cell_data = disp_cells[idx];
            end else begin
               res.range_error = 1'b1;
            end
         end
         default: ;
      endcase
      res.cursor_col = 7'(cur_col);
      res.cursor_row = 5'(cur_row);
      return res;
   endfunction

   function automatic void report_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
      fail_count++;
      $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         attr = TEXT_COLOR_RESET;
         fill_cells(1'b1);
         cur_col = 0;
         cur_row = 0;
         pending_replies.delete();
         fail_count = 0;
         replies_checked = 0;
      end else begin
         if (csr_wr_en) begin
            attr = csr_wr_data;
         end
         if (req_push && !req_full) begin
            pending_replies.push_back(apply_command(req_data));
         end
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (pending_replies.size() == 0) begin
               fail_count++;
               $display("%0d ns: response with no command outstanding, expected none, got 0x%0h",
                        $time, got);
            end else begin
               want = pending_replies.pop_front();
               replies_checked++;
               if (got.cursor_col !== want.cursor_col) begin
                  report_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
               end
               if (got.cursor_row !== want.cursor_row) begin
                  report_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
               end
               if (got.cell_data !== want.cell_data) begin
                  report_field("cell_data", want.cell_data, got.cell_data);
               end
               if (got.range_error !== want.range_error) begin
                  report_field("range_error", 16'(want.range_error), 16'(got.range_error));
               end
            end
         end
      end
      outstanding <= pending_replies.size();
   end

endmodule

@@ test/tb.sv @@
module tb;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 220;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   req_type    req_data;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   int fail_count;
   int replies_checked;
   int outstanding;

   int sent = 0;
   int reads_sent = 0;
   int sweeps_sent = 0;
   int colors_used = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int cycles = 0;
   bit steady = 1'b0;

   text_mode_char_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcw_screen_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .replies_checked (replies_checked),
      .outstanding     (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding", cycles, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: random pops, or constant pops while steady, plus one long hold when the sender asks for it.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            holds_done++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= steady || ($urandom_range(99) >= 28);
         end
      end
   end

   function automatic req_type make_cmd(input kind_type k, input logic [7:0] ch,
                                        input logic [7:0] c, input logic [7:0] r);
      req_type cmd;
      cmd.kind = k;
      cmd.char_code = ch;
      cmd.col = c;
      cmd.row = r;
      return cmd;
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(255));
   endfunction

   // Mostly printable text, with the cursor control codes and raw bytes mixed in.
   function automatic logic [7:0] pick_char();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 8'($urandom_range(126, 32));
      if (sel < 80) return CH_NEWLINE;
      if (sel < 85) return CH_TAB;
      if (sel < 90) return CH_RETURN;
      return rnd8();
   endfunction

   // Coordinates cluster near the top of the screen so reads hit written cells.
   function automatic logic [7:0] pick_coord(input int limit, input int near);
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return 8'($urandom_range(near - 1));
      if (sel < 85) return 8'($urandom_range(limit - 1));
      if (sel < 92) return 8'(limit - 1 + $urandom_range(1));
      return rnd8();
   endfunction

   // Entered and left at a falling edge; req_push stays high for back-to-back transactions.
   task automatic send_cmd(input req_type cmd);
      if (!steady) begin
         while ($urandom_range(99) < 28) begin
            req_push <= 1'b0;
            @(negedge clock);
         end
      end
      req_push <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      sent++;
      if (cmd.kind == KIND_READ) reads_sent++;
      if (cmd.kind inside {KIND_CLEAR_ALL, KIND_CLEAR_BACK, KIND_FLIP}) sweeps_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_color(input logic [7:0] shade);
      csr_wr_en <= 1'b1;
      csr_wr_data <= shade;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      colors_used++;
   endtask

   task automatic random_step();
      int       sel;
      int       len;
      req_type  cmd;
      sel = $urandom_range(999);
      if (sel < 60) begin
         // A line of text closed by a newline.
         len = $urandom_range(40, 3);
         repeat (len) send_cmd(make_cmd(KIND_PUT_BOTH, 8'($urandom_range(126, 32)),
                                        rnd8(), rnd8()));
         send_cmd(make_cmd(KIND_PUT_BOTH, CH_NEWLINE, rnd8(), rnd8()));
      end else if (sel < 400) begin
         send_cmd(make_cmd(KIND_PUT_BOTH, pick_char(), rnd8(), rnd8()));
      end else if (sel < 470) begin
         send_cmd(make_cmd(KIND_PUT_BACK, pick_char(), rnd8(), rnd8()));
      end else if (sel < 560) begin
         cmd = make_cmd(KIND_PUT_AT, rnd8(), pick_coord(80, 80), pick_coord(25, 4));
         send_cmd(cmd);
         if ($urandom_range(1) == 1) begin
            cmd.kind = KIND_READ;
            send_cmd(cmd);
         end
      end else if (sel < 640) begin
         send_cmd(make_cmd(KIND_SET_CURSOR, rnd8(), pick_coord(80, 80), pick_coord(25, 4)));
      end else if (sel < 950) begin
         send_cmd(make_cmd(KIND_READ, rnd8(), pick_coord(80, 80), pick_coord(25, 4)));
      end else if (sel < 965) begin
         send_cmd(make_cmd(KIND_CLEAR_ALL, rnd8(), rnd8(), rnd8()));
      end else if (sel < 980) begin
         send_cmd(make_cmd(KIND_CLEAR_BACK, rnd8(), rnd8(), rnd8()));
      end else begin
         send_cmd(make_cmd(KIND_FLIP, rnd8(), rnd8(), rnd8()));
      end
   endtask

   initial begin
      logic [7:0] shade;
      int         target;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Wait out the clearing pass that follows reset.
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);

      // Directed commands under the reset color.
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd80, 8'd0));
      send_cmd(make_cmd(KIND_READ, 8'hFF, 8'd0, 8'd25));
      send_cmd(make_cmd(KIND_PUT_BOTH, 8'h41, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BOTH, CH_TAB, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BOTH, 8'hFF, 8'hFF, 8'hFF));
      send_cmd(make_cmd(KIND_PUT_BOTH, CH_RETURN, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BOTH, CH_NEWLINE, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BOTH, 8'h00, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_SET_CURSOR, 8'h00, 8'd255, 8'd255));
      send_cmd(make_cmd(KIND_PUT_BOTH, 8'h5A, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd79, 8'd24));
      send_cmd(make_cmd(KIND_SET_CURSOR, 8'h00, 8'd79, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BOTH, CH_TAB, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_PUT_BACK, 8'h42, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd0, 8'd1));
      send_cmd(make_cmd(KIND_FLIP, 8'h00, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd0, 8'd1));
      send_cmd(make_cmd(KIND_PUT_AT, CH_TAB, 8'd79, 8'd24));
      send_cmd(make_cmd(KIND_PUT_AT, 8'h33, 8'd80, 8'd3));
      send_cmd(make_cmd(KIND_READ, 8'h00, 8'd79, 8'd24));
      send_cmd(make_cmd(KIND_SET_CURSOR, 8'h00, 8'd0, 8'd24));
      send_cmd(make_cmd(KIND_PUT_BOTH, CH_NEWLINE, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_CLEAR_BACK, 8'h00, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_FLIP, 8'h00, 8'd0, 8'd0));
      send_cmd(make_cmd(KIND_CLEAR_ALL, 8'h00, 8'd0, 8'd0));

      // Random phases, each under its own text color.
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: shade = 8'hFF;
            1: shade = 8'h00;
            2: shade = 8'($urandom_range(254, 1));
            default: shade = 8'h1E;
         endcase
         write_color(shade);
         steady = (phase == 2);
         send_cmd(make_cmd(KIND_CLEAR_ALL, rnd8(), rnd8(), rnd8()));
         // Second phase: once the clear is done, the response side holds off while
         // commands keep coming.
         if (phase == 1) begin
            wait_idle();
            hold_requests++;
         end
         target = sent + PHASE_ITEMS;
         while (sent < target) random_step();
      end
      steady = 1'b0;
      req_push <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d commands (%0d reads, %0d clears or flips) under %0d written colors",
               sent, reads_sent, sweeps_sent, colors_used);
      $display("Checked %0d responses, including a long response-side hold", replies_checked);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
